// ----- src/pawo_pkg.sv -----
package pawo_pkg;

  localparam int FREQ_W              = 18;
  localparam int SAMPLE_W            = 16;
  localparam int SEL_W               = 3;
  localparam int PHASE_INT_W         = 7;
  localparam int DEF_PHASE_FRAC_BITS = 25;
  localparam int DEF_SAMPLE_RATE     = 22050;

  typedef enum logic [SEL_W-1:0] {
    WAVE_TRI,
    WAVE_UNEVEN,
    WAVE_SAW,
    WAVE_SQUARE,
    WAVE_PULSE,
    WAVE_ORGAN,
    WAVE_DETUNE,
    WAVE_RAMP
  } wave_t;

endpackage

// ----- src/pawo_inc.sv -----
module pawo_inc
  import pawo_pkg::*;
#(
  parameter int PHASE_FRAC_BITS = DEF_PHASE_FRAC_BITS,
  parameter int SAMPLE_RATE     = DEF_SAMPLE_RATE
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   up_valid,
  output logic                                   up_stall,
  input  logic [FREQ_W-1:0]                      up_freq,
  output logic                                   dn_valid,
  input  logic                                   dn_stall,
  output logic [PHASE_FRAC_BITS+PHASE_INT_W-1:0] dn_inc
);

  localparam int PW    = PHASE_FRAC_BITS + PHASE_INT_W;
  localparam int DEN   = 16 * SAMPLE_RATE;
  localparam int GUARD = FREQ_W + 2;
  localparam logic [63:0] RECIP = (64'd1 << (PHASE_FRAC_BITS + GUARD)) / DEN;
  localparam int RW    = $clog2(RECIP + 64'd1);
  localparam int PRW   = FREQ_W + RW;
  localparam int QW    = PRW - GUARD;
  localparam int IW    = QW + 1;
  localparam int DW    = $clog2(DEN + 1);
  localparam int RMW   = DW + 2;
  localparam int NW    = FREQ_W + PHASE_FRAC_BITS + 1;

  localparam logic [RW-1:0]  RECIP_K = RECIP[RW-1:0];
  localparam logic [RMW-1:0] DEN_K   = RMW'(DEN);
  localparam logic [RMW-1:0] DEN2_K  = RMW'(2 * DEN);
  localparam logic [RMW-1:0] DEN3_K  = RMW'(3 * DEN);
  localparam logic [NW-1:0]  HALF_K  = NW'(DEN / 2);

  // stages: 0 input reg, 1 reciprocal product, 2 back product, 3 corrected inc
  logic [3:0]        v_r;
  logic [3:0]        load;
  logic [FREQ_W-1:0] freq_a_r, freq_b_r;
  logic [PRW-1:0]    prod;
  logic [QW-1:0]     q0_b_r, q0_c_r;
  logic [RMW-1:0]    qd_nxt, qd_c_r, nlo_c_r, rem;
  logic [NW-1:0]     n_full;
  logic [1:0]        corr;
  logic [IW-1:0]     inc_nxt, inc_d_r;

  always_comb begin
    load[3] = !v_r[3] || !dn_stall;
    load[2] = !v_r[2] || load[3];
    load[1] = !v_r[1] || load[2];
    load[0] = !v_r[0] || load[1];
  end

  assign up_stall = !load[0];
  assign dn_valid = v_r[3];
  assign dn_inc   = PW'(inc_d_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (load[0]) v_r[0] <= up_valid;
      if (load[1]) v_r[1] <= v_r[0];
      if (load[2]) v_r[2] <= v_r[1];
      if (load[3]) v_r[3] <= v_r[2];
    end
  end

  assign prod    = PRW'(freq_a_r) * PRW'(RECIP_K);
  assign n_full  = {1'b0, freq_b_r, {PHASE_FRAC_BITS{1'b0}}} + HALF_K;
  assign qd_nxt  = RMW'(q0_b_r) * DEN_K;
  // remainder is only needed modulo 4*DEN, it stays below 3*DEN
  assign rem     = nlo_c_r - qd_c_r;

  always_comb begin
    priority if (rem >= DEN2_K) begin
      corr = 2'd2;
    end else if (rem >= DEN_K) begin
      corr = 2'd1;
    end else begin
      corr = 2'd0;
    end
  end

  assign inc_nxt = IW'(q0_c_r) + IW'(corr);

  always_ff @(posedge clk) begin
    if (load[0]) freq_a_r <= up_freq;
    if (load[1]) begin
      freq_b_r <= freq_a_r;
      q0_b_r   <= prod[PRW-1:GUARD];
    end
    if (load[2]) begin
      q0_c_r  <= q0_b_r;
      qd_c_r  <= qd_nxt;
      nlo_c_r <= n_full[RMW-1:0];
    end
    if (load[3]) inc_d_r <= inc_nxt;
  end

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[2] |-> rem < DEN3_K)
    else $error("increment remainder out of range");

endmodule

// ----- src/pawo_wave.sv -----
module pawo_wave
  import pawo_pkg::*;
#(
  parameter int PHASE_FRAC_BITS = DEF_PHASE_FRAC_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   up_valid,
  output logic                                   up_stall,
  input  logic [PHASE_FRAC_BITS+PHASE_INT_W-1:0] up_phase,
  input  wave_t                                  wave_sel,
  output logic                                   dn_valid,
  input  logic                                   dn_stall,
  output logic signed [SAMPLE_W-1:0]             dn_sample
);

  localparam int F   = PHASE_FRAC_BITS;
  localparam int PW  = F + PHASE_INT_W;
  localparam int NW  = F + 10;
  localparam int ZW  = 20;
  localparam int QW  = 17;
  localparam int MW  = ZW + 1;
  localparam int SH0 = F - 16;

  localparam logic signed [NW-1:0] ONE     = NW'(64'd1 << F);
  localparam logic signed [NW-1:0] ONE_7   = NW'(64'd7 << F);
  localparam logic signed [NW-1:0] ONE_17  = NW'(64'd17 << F);
  localparam logic signed [NW-1:0] ONE_64  = NW'(64'd64 << F);
  localparam logic signed [NW-1:0] ONE_128 = NW'(64'd128 << F);
  localparam logic [F-1:0] T_HALF   = F'(64'd1 << (F - 1));
  localparam logic [F-1:0] T_PULSE  = F'(64'd5 << (F - 4));
  localparam logic [F-1:0] T_UNEVEN = F'(64'd7 << (F - 3));

  typedef enum logic [1:0] {DIV1, DIV3, DIV5, DIV7} div_t;

  function automatic logic [2:0] div_val(input div_t dv);
    logic [2:0] r;
    unique case (dv)
      DIV1: r = 3'd1;
      DIV3: r = 3'd3;
      DIV5: r = 3'd5;
      DIV7: r = 3'd7;
    endcase
    return r;
  endfunction

  // floor(2^ZW / d)
  function automatic logic [MW-1:0] div_recip(input div_t dv);
    logic [MW-1:0] r;
    unique case (dv)
      DIV1: r = MW'(64'd1 << ZW);
      DIV3: r = MW'((64'd1 << ZW) / 3);
      DIV5: r = MW'((64'd1 << ZW) / 5);
      DIV7: r = MW'((64'd1 << ZW) / 7);
    endcase
    return r;
  endfunction

  function automatic logic signed [NW-1:0] abs_s(input logic signed [NW-1:0] x);
    return (x < 0) ? -x : x;
  endfunction

  // stages: 0 scaled numerator, 1 reciprocal product, 2 output
  logic [2:0]              v_r;
  logic [2:0]              load;
  logic [F-1:0]            t;
  logic signed [NW-1:0]    ts, t2, t4, det_s, a_org, b_mix, num, ofs, z_full;
  logic [PW-1:0]           det;
  logic [7:0]              c_k;
  logic [2:0]              e_k;
  logic [5:0]              sh;
  div_t                    dv_nxt, dv_1_r, dv_2_r;
  logic signed [ZW-1:0]    z_1_r;
  logic [ZW-1:0]           zp;
  logic [ZW+MW-1:0]        prod;
  logic [QW-1:0]           q0_2_r, qf;
  logic [3:0]              zlo_2_r, rem4;
  logic [2:0]              dval_2;
  logic signed [QW:0]      val;
  logic signed [SAMPLE_W-1:0] sample_nxt, sample_r;

  always_comb begin
    load[2] = !v_r[2] || !dn_stall;
    load[1] = !v_r[1] || load[2];
    load[0] = !v_r[0] || load[1];
  end

  assign up_stall  = !load[0];
  assign dn_valid  = v_r[2];
  assign dn_sample = sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (load[0]) v_r[0] <= up_valid;
      if (load[1]) v_r[1] <= v_r[0];
      if (load[2]) v_r[2] <= v_r[1];
    end
  end

  assign t     = up_phase[F-1:0];
  assign ts    = signed'(NW'(t));
  assign t2    = signed'(NW'({t, 1'b0}));
  assign t4    = signed'(NW'({t[F-2:0], 2'b00}));
  assign det   = (up_phase << 7) - up_phase;
  assign det_s = signed'(NW'(det));
  assign a_org = abs_s(t4 - ONE);
  assign b_mix = abs_s(t2 - ONE);

  // value = floor((num + c*2^(F-16)) / 2^(F-16+e) / d), d*2^e = 2c
  always_comb begin
    num    = ts;
    c_k    = 8'd1;
    e_k    = 3'd1;
    dv_nxt = DIV1;
    unique case (wave_sel)
      WAVE_TRI: begin
        num = abs_s((ts <<< 1) - ONE) - (ONE >>> 1);
      end
      WAVE_UNEVEN: begin
        if (t < T_UNEVEN) begin
          num    = (ts <<< 4) - ONE_7;
          c_k    = 8'd14;
          e_k    = 3'd2;
          dv_nxt = DIV7;
        end else begin
          num = ((ONE - ts) <<< 4) - ONE;
          c_k = 8'd2;
          e_k = 3'd2;
        end
      end
      WAVE_SAW: begin
        num    = (ts <<< 1) - ONE;
        c_k    = 8'd3;
        dv_nxt = DIV3;
      end
      WAVE_SQUARE: begin
        num = (t < T_HALF) ? (ONE >>> 2) : -(ONE >>> 2);
      end
      WAVE_PULSE: begin
        num = (t < T_PULSE) ? (ONE >>> 2) : -(ONE >>> 2);
      end
      WAVE_ORGAN: begin
        num    = (a_org <<< 4) + (a_org <<< 2) + (b_mix <<< 3) + (b_mix <<< 1) - ONE_17;
        c_k    = 8'd40;
        e_k    = 3'd4;
        dv_nxt = DIV5;
      end
      WAVE_DETUNE: begin
        num    = abs_s(det_s - ONE_64) + (b_mix <<< 7) - ONE_128;
        c_k    = 8'd192;
        e_k    = 3'd7;
        dv_nxt = DIV3;
      end
      WAVE_RAMP: begin
        num = ts;
      end
    endcase
  end

  assign ofs    = signed'(NW'(c_k) << SH0);
  assign sh     = 6'(SH0) + 6'(e_k);
  assign z_full = (num + ofs) >>> sh;

  // offset by d*2^16 so the divide sees a nonnegative value
  assign zp   = $unsigned(z_1_r) + ZW'({div_val(dv_1_r), 16'h0000});
  assign prod = (ZW + MW)'(zp) * (ZW + MW)'(div_recip(dv_1_r));

  assign dval_2 = div_val(dv_2_r);
  assign rem4   = zlo_2_r - (4'(dval_2) * q0_2_r[3:0]);
  assign qf     = q0_2_r + QW'(rem4 >= 4'(dval_2));
  assign val    = $signed({1'b0, qf}) - $signed((QW + 1)'(64'd1 << 16));

  always_comb begin
    priority if (val > $signed((QW + 1)'(32767))) begin
      sample_nxt = 16'sh7FFF;
    end else if (val < -$signed((QW + 1)'(32768))) begin
      sample_nxt = 16'sh8000;
    end else begin
      sample_nxt = val[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      z_1_r  <= z_full[ZW-1:0];
      dv_1_r <= dv_nxt;
    end
    if (load[1]) begin
      q0_2_r  <= prod[ZW +: QW];
      zlo_2_r <= zp[3:0];
      dv_2_r  <= dv_1_r;
    end
    if (load[2]) sample_r <= sample_nxt;
  end

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[1] |-> rem4 < {dval_2, 1'b0})
    else $error("sample divide remainder out of range");

endmodule

// ----- src/phase_accumulator_waveform_oscillator.sv -----
// Path: an accepted input beat passes the increment stages, the phase register
// and the waveform stages before out_valid rises.
// Throughput: one beat per cycle while out_stall is low; every stage is elastic,
// so bubbles close up and input is taken while a finished sample waits on out_stall.
// Phase increment: input register, then three stages (reciprocal multiply,
// back product, fix-up).
// Reset clears the phase, the waveform select (triangle) and all valids.
module phase_accumulator_waveform_oscillator
  import pawo_pkg::*;
#(
  parameter int PHASE_FRAC_BITS = DEF_PHASE_FRAC_BITS,
  parameter int SAMPLE_RATE     = DEF_SAMPLE_RATE
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [FREQ_W-1:0]          in_freq_hz_q4,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_sample_q15,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [SEL_W-1:0]           cfg_waveform_select
);

  localparam int PW = PHASE_FRAC_BITS + PHASE_INT_W;

  wave_t         sel_r;
  logic          inc_valid, inc_stall;
  logic [PW-1:0] inc;
  logic [PW-1:0] phase_r;
  logic          ph_v_r, ph_load, wave_stall;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= WAVE_TRI;
    end else if (cfg_valid && cfg_ready) begin
      sel_r <= wave_t'(cfg_waveform_select);
    end
  end

  pawo_inc #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS),
    .SAMPLE_RATE    (SAMPLE_RATE)
  ) u_inc (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_valid(in_valid),
    .up_stall(in_stall),
    .up_freq (in_freq_hz_q4),
    .dn_valid(inc_valid),
    .dn_stall(inc_stall),
    .dn_inc  (inc)
  );

  assign ph_load   = !ph_v_r || !wave_stall;
  assign inc_stall = !ph_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_v_r  <= 1'b0;
      phase_r <= '0;
    end else if (ph_load) begin
      ph_v_r <= inc_valid;
      if (inc_valid) phase_r <= phase_r + inc;
    end
  end

  pawo_wave #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
  ) u_wave (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (ph_v_r),
    .up_stall (wave_stall),
    .up_phase (phase_r),
    .wave_sel (sel_r),
    .dn_valid (out_valid),
    .dn_stall (out_stall),
    .dn_sample(out_sample_q15)
  );

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !ph_v_r)
    else $error("pipeline not empty after reset");

  a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(phase_r) |-> $past(inc_valid && ph_load))
    else $error("phase moved without an increment beat");

endmodule

// ----- sim/phase_accumulator_waveform_oscillator_tb.sv -----
`timescale 1ns / 1ps

module phase_accumulator_waveform_oscillator_tb;
  import pawo_pkg::*;

  localparam int     FRAC      = DEF_PHASE_FRAC_BITS;
  localparam int     PH_W      = PHASE_INT_W + FRAC;
  localparam longint ONE       = longint'(1) << FRAC;
  localparam longint TICK_DEN  = 16 * DEF_SAMPLE_RATE;
  localparam int     GAP_MAX   = 11;
  localparam int     HOLD_LEN  = 90;
  localparam int     PAD       = 12;
  localparam int     WATCHDOG  = 2000;
  localparam int     RAND_LEN  = 128;
  localparam int     N_PHASES  = 12;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [FREQ_W-1:0]          in_freq_hz_q4 = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample_q15;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [SEL_W-1:0]           cfg_waveform_select = '0;

  phase_accumulator_waveform_oscillator i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_freq_hz_q4       (in_freq_hz_q4),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_sample_q15      (out_sample_q15),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_waveform_select (cfg_waveform_select)
  );

  always #10 clk = ~clk;

  logic [FREQ_W-1:0]          freq_pending [$];
  logic signed [SAMPLE_W-1:0] sample_due [$];

  logic           in_took = 1'b0;
  logic           out_took = 1'b0;
  logic           cfg_took = 1'b0;
  wave_t          wave_sel = WAVE_TRI;
  logic [PH_W-1:0] osc_phase = '0;
  logic [PH_W-1:0] plan_phase = '0;
  int             beats_accepted = 0;
  int             beats_queued = 0;
  int             samples_checked = 0;
  int             settings_used = 0;
  int             fails = 0;
  int             idle_cycles = 0;
  int             tx_gap = 0;
  int             rx_wait = 0;
  int             rx_hold = 0;
  bit             tx_burst = 1'b0;
  bit             rx_burst = 1'b0;
  bit             sender_pause = 1'b0;
  bit             tx_paused = 1'b0;
  bit             hold_req = 1'b0;
  bit             hold_ack = 1'b0;

  wave_t rand_plan [N_PHASES] = '{WAVE_TRI, WAVE_RAMP, WAVE_DETUNE, WAVE_ORGAN, WAVE_SAW,
                                  WAVE_SQUARE, WAVE_PULSE, WAVE_UNEVEN, WAVE_DETUNE,
                                  WAVE_RAMP, WAVE_ORGAN, WAVE_TRI};

  function automatic logic [PH_W-1:0] phase_inc(logic [FREQ_W-1:0] f);
    longint num;
    num = (longint'(f) << FRAC) + TICK_DEN / 2;
    return PH_W'(num / TICK_DEN);
  endfunction

  function automatic longint div_floor(longint n, longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] q15_round(longint num, longint den);
    longint v;
    v = div_floor(num * 65536 + den, 2 * den);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return SAMPLE_W'(v);
  endfunction

  function automatic longint mag(longint a, longint b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] wave_sample(wave_t sel, logic [PH_W-1:0] ph);
    longint t, a, b, c, d, mask2;
    t = longint'(ph[FRAC-1:0]);
    mask2 = (ONE << 1) - 1;
    case (sel)
      WAVE_TRI:    return q15_round(mag(2 * t, ONE) - ONE / 2, ONE);
      WAVE_UNEVEN: begin
        if (t < (ONE / 8) * 7) return q15_round(16 * t - 7 * ONE, 14 * ONE);
        return q15_round(16 * (ONE - t) - ONE, 2 * ONE);
      end
      WAVE_SAW:    return q15_round(2 * t - ONE, 3 * ONE);
      WAVE_SQUARE: return q15_round(t < ONE / 2 ? 1 : -1, 4);
      WAVE_PULSE:  return q15_round(t < (ONE / 16) * 5 ? 1 : -1, 4);
      WAVE_ORGAN: begin
        a = mag((4 * t) & mask2, ONE);
        b = mag((2 * t) & mask2, ONE);
        return q15_round(20 * a + 10 * b - 17 * ONE, 40 * ONE);
      end
      WAVE_DETUNE: begin
        c = mag((2 * t) & mask2, ONE);
        d = (longint'(ph) * 127) & ((ONE << 7) - 1);
        return q15_round(mag(d, 64 * ONE) + 128 * c - 128 * ONE, 192 * ONE);
      end
      default:     return q15_round(t, ONE);
    endcase
  endfunction

  // lowest frequency whose increment puts the phase fraction inside [lo, hi]
  function automatic int freq_landing(logic [PH_W-1:0] ph, longint lo, longint hi);
    logic [PH_W-1:0] nxt;
    longint fr;
    for (int f = 0; f < (1 << FREQ_W); f++) begin
      nxt = ph + phase_inc(FREQ_W'(f));
      fr = longint'(nxt[FRAC-1:0]);
      if (fr >= lo && fr <= hi) return f;
    end
    return -1;
  endfunction

  function automatic logic [FREQ_W-1:0] rand_freq();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return FREQ_W'($urandom);
      4, 5, 6:    return FREQ_W'($urandom_range(0, 176400));
      7:          return FREQ_W'($urandom_range(0, 400));
      8: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return FREQ_W'(176400);
          2:       return '1;
          default: return FREQ_W'(1);
        endcase
      end
      default:    return FREQ_W'(176400 - $urandom_range(0, 64));
    endcase
  endfunction

  task automatic queue_freq(logic [FREQ_W-1:0] f);
    freq_pending.push_back(f);
    plan_phase = plan_phase + phase_inc(f);
    beats_queued++;
  endtask

  task automatic aim_phase(longint lo, longint hi);
    int f;
    f = freq_landing(plan_phase, lo, hi);
    if (f < 0) begin
      queue_freq(FREQ_W'(176400));
      f = freq_landing(plan_phase, lo, hi);
    end
    queue_freq(FREQ_W'(f));
  endtask

  task automatic settle();
    do @(negedge clk); while (!(beats_accepted == beats_queued && sample_due.size() == 0));
    repeat (PAD) @(negedge clk);
  endtask

  task automatic write_sel(wave_t s);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_waveform_select <= s;
    do @(negedge clk); while (!cfg_took);
    cfg_valid <= 1'b0;
    settings_used++;
    @(posedge clk);
  endtask

  // sender
  always @(negedge clk) begin : drv
    logic              v;
    logic [FREQ_W-1:0] f;
    v = in_valid;
    f = in_freq_hz_q4;
    if (rst_n) begin
      if (v && in_took) begin
        v = 1'b0;
        tx_gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (!v) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (!sender_pause && freq_pending.size() > 0) begin
          v = 1'b1;
          f = freq_pending.pop_front();
        end
      end
      tx_paused = sender_pause && !v;
    end
    in_valid <= v;
    in_freq_hz_q4 <= f;
  end

  // receiver
  always @(negedge clk) begin : rcv
    if (rst_n) begin
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        rx_hold = HOLD_LEN;
      end
      if (out_took) rx_wait = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
      else if (rx_wait > 0) rx_wait--;
      if (rx_hold > 0) rx_hold--;
    end
    out_stall <= (rx_wait > 0) || (rx_hold > 0);
  end

  // beat capture, prediction and compare
  always @(posedge clk) begin : mon
    logic signed [SAMPLE_W-1:0] want;
    logic                       any_beat;
    if (!rst_n) begin
      in_took <= 1'b0;
      out_took <= 1'b0;
      cfg_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      out_took <= out_valid && !out_stall;
      cfg_took <= cfg_valid && cfg_ready;
      any_beat = (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready);
      if (cfg_valid && cfg_ready) wave_sel = wave_t'(cfg_waveform_select);
      if (out_valid && !out_stall) begin
        if (sample_due.size() == 0) begin
          if (fails < 10) $display("unexpected sample %0d", out_sample_q15);
          fails++;
        end else begin
          want = sample_due.pop_front();
          if (out_sample_q15 !== want) begin
            if (fails < 10)
              $display("sample %0d: expected %0d, got %0d", samples_checked, want,
                       out_sample_q15);
            fails++;
          end
          samples_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        osc_phase = osc_phase + phase_inc(in_freq_hz_q4);
        sample_due.push_back(wave_sample(wave_sel, osc_phase));
        beats_accepted++;
      end
      idle_cycles = any_beat ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog: no beat for %0d cycles", idle_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stim
    int start;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // triangle out of reset: frequency extremes, including above range
    queue_freq('0);
    queue_freq(FREQ_W'(1));
    queue_freq(FREQ_W'(176400));
    queue_freq('1);
    queue_freq(FREQ_W'(88200));
    queue_freq('1);
    settle();

    // ramp: saturation just below the wrap, then just past it
    write_sel(WAVE_RAMP);
    aim_phase(ONE - 512, ONE - 1);
    queue_freq('0);
    aim_phase(ONE - 900, ONE - 600);
    aim_phase(0, 300);
    settle();

    write_sel(WAVE_UNEVEN);
    aim_phase((ONE / 8) * 7 - 200, (ONE / 8) * 7 - 1);
    aim_phase((ONE / 8) * 7, (ONE / 8) * 7 + 200);
    settle();

    write_sel(WAVE_SQUARE);
    aim_phase(ONE / 2 - 200, ONE / 2 - 1);
    aim_phase(ONE / 2, ONE / 2 + 200);
    settle();

    write_sel(WAVE_PULSE);
    aim_phase((ONE / 16) * 5 - 200, (ONE / 16) * 5 - 1);
    aim_phase((ONE / 16) * 5, (ONE / 16) * 5 + 200);
    settle();

    write_sel(WAVE_SAW);
    queue_freq(FREQ_W'(176400));
    settle();
    write_sel(WAVE_ORGAN);
    queue_freq(FREQ_W'(44100));
    settle();
    write_sel(WAVE_DETUNE);
    queue_freq('1);
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      write_sel(rand_plan[p]);
      tx_burst = (p == 2) || (p == 8) || (p == 9);
      rx_burst = (p == 8) || (p == 10);
      start = beats_accepted;
      for (int k = 0; k < RAND_LEN; k++) queue_freq(rand_freq());
      if (p == 2) begin
        // output held off while the sender keeps offering
        do @(negedge clk); while (beats_accepted < start + 20);
        @(posedge clk);
        hold_req = ~hold_req;
      end
      if (p == 5) begin
        do @(negedge clk); while (beats_accepted < start + RAND_LEN / 3);
        @(posedge clk);
        sender_pause = 1'b1;
        do @(posedge clk); while (!tx_paused);
        do @(negedge clk); while (sample_due.size() != 0);
        @(posedge clk);
        sender_pause = 1'b0;
      end
      settle();
    end

    $display("checked %0d samples across %0d waveform writes, with edge landings, ramp top,",
             samples_checked, settings_used);
    $display("a long output hold and a sender drain; %0d mismatches, %0d left over",
             fails, sample_due.size());
    if (fails == 0 && sample_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/pawo_pkg.sv
src/pawo_inc.sv
src/pawo_wave.sv
src/phase_accumulator_waveform_oscillator.sv
sim/phase_accumulator_waveform_oscillator_tb.sv
